@@ src/cbbc_pkg.sv @@
// Shared types, codes and index helpers for the count-based classifier.
package cbbc_pkg;

    localparam int NUM_CLASSES = 3;
    localparam int NUM_BINS    = 6;
    localparam int NUM_EDGES   = 5;
    localparam int EDGE_W      = 12;
    localparam int CFG_ADDR_W  = 3;
    localparam int GC_DEPTH    = 2 * NUM_CLASSES;
    localparam int BC_DEPTH    = NUM_BINS * NUM_CLASSES;
    localparam int GC_IDX_W    = $clog2(GC_DEPTH);
    localparam int BC_IDX_W    = $clog2(BC_DEPTH);
    localparam int EDGE_IDX_W  = $clog2(NUM_EDGES);
    localparam int BIN_W       = $clog2(NUM_BINS);

    // Configuration register indexes.
    localparam logic [CFG_ADDR_W-1:0] REG_EDGE_ONE   = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_EDGE_TWO   = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_EDGE_THREE = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_EDGE_FOUR  = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_EDGE_FIVE  = 3'd4;

    localparam logic [EDGE_W-1:0] EDGE_ONE_RST   = 12'd1600;
    localparam logic [EDGE_W-1:0] EDGE_TWO_RST   = 12'd1700;
    localparam logic [EDGE_W-1:0] EDGE_THREE_RST = 12'd1800;
    localparam logic [EDGE_W-1:0] EDGE_FOUR_RST  = 12'd1900;
    localparam logic [EDGE_W-1:0] EDGE_FIVE_RST  = 12'd2000;

    // Item kinds, gender and class codes.
    localparam logic       KIND_TRAIN    = 1'b0;
    localparam logic       KIND_CLASSIFY = 1'b1;
    localparam logic [1:0] GENDER_MALE   = 2'd0;
    localparam logic [1:0] GENDER_FEMALE = 2'd1;
    localparam logic [1:0] CLASS_SHORT   = 2'd0;
    localparam logic [1:0] CLASS_TALL    = 2'd2;
    localparam logic [1:0] LABEL_UNKNOWN = 2'd3;

    localparam logic [EDGE_IDX_W-1:0] LAST_EDGE = EDGE_IDX_W'(NUM_EDGES - 1);
    localparam logic [BIN_W-1:0]      OPEN_BIN  = BIN_W'(NUM_BINS - 1);

    typedef struct packed {
        logic inc_gender;
        logic inc_bin;
    } tbl_ctrl_t;

    typedef struct packed {
        logic clear;
        logic mul_en;
        logic cmp_en;
    } unit_ctrl_t;

    // Row gender_sel (0 male, 1 female) of the gender-by-class table.
    function automatic logic [GC_IDX_W-1:0] gc_index(input logic gender_sel,
                                                     input logic [1:0] cls);
        logic [GC_IDX_W-1:0] base;
        base = gender_sel ? GC_IDX_W'(NUM_CLASSES) : '0;
        return base + GC_IDX_W'(cls);
    endfunction

    // bin * 3 + class, with the times three done as a shift and an add.
    function automatic logic [BC_IDX_W-1:0] bc_index(input logic [BIN_W-1:0] bin,
                                                     input logic [1:0] cls);
        return BC_IDX_W'({bin, 1'b0}) + BC_IDX_W'(bin) + BC_IDX_W'(cls);
    endfunction

endpackage

@@ src/cbbc_tables.sv @@
// Gender-by-class and bin-by-class count tables with saturating increment.
module cbbc_tables #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  cbbc_pkg::tbl_ctrl_t               ctrl,
    input  logic [cbbc_pkg::GC_IDX_W-1:0]     gc_idx,
    input  logic [cbbc_pkg::BC_IDX_W-1:0]     bc_idx,
    output logic [COUNT_WIDTH-1:0]            gc_count,
    output logic [COUNT_WIDTH-1:0]            bc_count
);
    import cbbc_pkg::*;

    logic [COUNT_WIDTH-1:0] gc_reg [GC_DEPTH];
    logic [COUNT_WIDTH-1:0] bc_reg [BC_DEPTH];

    assign gc_count = gc_reg[gc_idx];
    assign bc_count = bc_reg[bc_idx];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < GC_DEPTH; i++) begin
                gc_reg[i] <= '0;
            end
            for (int i = 0; i < BC_DEPTH; i++) begin
                bc_reg[i] <= '0;
            end
        end else begin
            if (ctrl.inc_gender && (gc_count != '1)) begin
                gc_reg[gc_idx] <= gc_count + COUNT_WIDTH'(1);
            end
            if (ctrl.inc_bin && (bc_count != '1)) begin
                bc_reg[bc_idx] <= bc_count + COUNT_WIDTH'(1);
            end
        end
    end

endmodule

@@ src/cbbc_unit.sv @@
// Shared multiply and compare unit that tracks the best class product.
module cbbc_unit #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  cbbc_pkg::unit_ctrl_t    ctrl,
    input  logic [COUNT_WIDTH-1:0]  op_a,
    input  logic [COUNT_WIDTH-1:0]  op_b,
    input  logic [1:0]              cls,
    output logic [1:0]              best_class
);
    import cbbc_pkg::*;

    localparam int PW = 2 * COUNT_WIDTH;

    logic [PW-1:0] prod_reg;
    logic [PW-1:0] best_p_reg;
    logic [1:0]    best_reg;

    assign best_class = best_reg;

    // The product is registered and compared in the following cycle.
    always_ff @(posedge aclk) begin
        if (ctrl.mul_en) begin
            prod_reg <= PW'(op_a) * PW'(op_b);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            best_p_reg <= '0;
            best_reg   <= CLASS_SHORT;
        end else if (ctrl.clear) begin
            best_p_reg <= '0;
            best_reg   <= CLASS_SHORT;
        end else if (ctrl.cmp_en && (prod_reg > best_p_reg)) begin
            best_p_reg <= prod_reg;
            best_reg   <= cls;
        end
    end

endmodule

@@ src/count_based_bayes_classifier.sv @@
// Top level of the count-based classifier: sequencer, bin edges and result register.
//
// Input items arrive as stream transfers on s_tvalid/s_tready. s_tuser is the item
// kind (0 train, 1 classify); s_tdata packs gender, height in mm and class label.
// Train items bump the gender-by-class and bin-by-class counters (saturating) and
// give no result. Classify items give one transfer on m_tdata with the class whose
// product of gender-class and bin-class counts is largest, ties to the lower class.
// The bin edges are written through cfg_wr_en/cfg_addr/cfg_wdata; the user must write
// them only while idle, which the block does not enforce. One shared comparator bins
// the height, one edge per cycle, and one shared multiplier with its comparator takes
// the three classes in turn through ST_MUL and ST_CMP. A train item passes ST_BIN
// and ST_TRAIN; a classify item ends in ST_OUT, which loads its result register.
// The output register lets the next item be accepted while a result waits; if the
// receiver stalls with a result still held, the next classify item waits before
// loading its own. Reset clears all counters, restores the default edges and
// empties the output register.
module count_based_bayes_classifier #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Input channel.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [1:0] gender, [13:2] height_mm, [15:14] class_label
    input  logic        s_tuser,   // [0] kind
    // Result channel.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [1:0] predicted_class, [7:2] zero
    // Configuration write port.
    input  logic                          cfg_wr_en,
    input  logic [cbbc_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [cbbc_pkg::EDGE_W-1:0]   cfg_wdata
);
    import cbbc_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_BIN   = 6'b000010,
        ST_TRAIN = 6'b000100,
        ST_MUL   = 6'b001000,
        ST_CMP   = 6'b010000,
        ST_OUT   = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic [EDGE_W-1:0]     edge_reg [NUM_EDGES];
    logic [EDGE_IDX_W-1:0] edge_idx_reg, edge_idx_next;
    logic [BIN_W-1:0]      bin_reg, bin_next;
    logic [1:0]            cls_reg, cls_next;
    logic                  kind_reg;
    logic [1:0]            gender_reg;
    logic [EDGE_W-1:0]     height_reg;
    logic [1:0]            label_reg;
    logic                  m_tvalid_reg, m_tvalid_next;
    logic [1:0]            pred_reg, pred_next;

    tbl_ctrl_t              tbl_ctrl;
    unit_ctrl_t             unit_ctrl;
    logic [GC_IDX_W-1:0]    gc_idx;
    logic [BC_IDX_W-1:0]    bc_idx;
    logic [COUNT_WIDTH-1:0] gc_count;
    logic [COUNT_WIDTH-1:0] bc_count;
    logic [1:0]             best_class;
    logic                   s_xfer;
    logic                   below_edge;
    logic                   gender_sel;
    logic                   out_free;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_xfer   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'b0, pred_reg};
    assign out_free = !m_tvalid_reg || m_tready;

    assign below_edge = height_reg < edge_reg[edge_idx_reg];

    // Training uses the label; classification walks the classes. Any non-male
    // gender reads the female row.
    assign gender_sel = (gender_reg != GENDER_MALE);
    always_comb begin
        if (state_reg == ST_TRAIN) begin
            gc_idx = gc_index(gender_reg[0], label_reg);
            bc_idx = bc_index(bin_reg, label_reg);
        end else begin
            gc_idx = gc_index(gender_sel, cls_reg);
            bc_idx = bc_index(bin_reg, cls_reg);
        end
    end

    cbbc_tables #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_tables (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (tbl_ctrl),
        .gc_idx   (gc_idx),
        .bc_idx   (bc_idx),
        .gc_count (gc_count),
        .bc_count (bc_count)
    );

    cbbc_unit #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_unit (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctrl       (unit_ctrl),
        .op_a       (gc_count),
        .op_b       (bc_count),
        .cls        (cls_reg),
        .best_class (best_class)
    );

    always_comb begin
        state_next    = state_reg;
        edge_idx_next = edge_idx_reg;
        bin_next      = bin_reg;
        cls_next      = cls_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        pred_next     = pred_reg;
        tbl_ctrl      = '0;
        unit_ctrl     = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_xfer) begin
                    edge_idx_next = '0;
                    state_next    = ST_BIN;
                end
            end
            ST_BIN: begin
                if (below_edge || (edge_idx_reg == LAST_EDGE)) begin
                    bin_next        = below_edge ? BIN_W'(edge_idx_reg) : OPEN_BIN;
                    cls_next        = CLASS_SHORT;
                    unit_ctrl.clear = 1'b1;
                    state_next      = (kind_reg == KIND_TRAIN) ? ST_TRAIN : ST_MUL;
                end else begin
                    edge_idx_next = edge_idx_reg + EDGE_IDX_W'(1);
                end
            end
            ST_TRAIN: begin
                if (label_reg != LABEL_UNKNOWN) begin
                    tbl_ctrl.inc_gender = (gender_reg == GENDER_MALE) ||
                                          (gender_reg == GENDER_FEMALE);
                    tbl_ctrl.inc_bin    = 1'b1;
                end
                state_next = ST_IDLE;
            end
            ST_MUL: begin
                unit_ctrl.mul_en = 1'b1;
                state_next       = ST_CMP;
            end
            ST_CMP: begin
                unit_ctrl.cmp_en = 1'b1;
                if (cls_reg == CLASS_TALL) begin
                    state_next = ST_OUT;
                end else begin
                    cls_next   = cls_reg + 2'd1;
                    state_next = ST_MUL;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    pred_next     = best_class;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
            edge_idx_reg <= '0;
            cls_reg      <= CLASS_SHORT;
            bin_reg      <= '0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            edge_idx_reg <= edge_idx_next;
            cls_reg      <= cls_next;
            bin_reg      <= bin_next;
        end
    end

    always_ff @(posedge aclk) begin
        pred_reg <= pred_next;
        if (s_xfer) begin
            kind_reg   <= s_tuser;
            gender_reg <= s_tdata[1:0];
            height_reg <= s_tdata[13:2];
            label_reg  <= s_tdata[15:14];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            edge_reg[0] <= EDGE_ONE_RST;
            edge_reg[1] <= EDGE_TWO_RST;
            edge_reg[2] <= EDGE_THREE_RST;
            edge_reg[3] <= EDGE_FOUR_RST;
            edge_reg[4] <= EDGE_FIVE_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_EDGE_ONE:   edge_reg[0] <= cfg_wdata;
                REG_EDGE_TWO:   edge_reg[1] <= cfg_wdata;
                REG_EDGE_THREE: edge_reg[2] <= cfg_wdata;
                REG_EDGE_FOUR:  edge_reg[3] <= cfg_wdata;
                REG_EDGE_FIVE:  edge_reg[4] <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for the count-based classifier: stream driver, result monitor, predictor.
module testbench;
    import cbbc_pkg::*;

    // A narrow counter width makes saturation reachable within a short run.
    localparam int CNT_W        = 8;
    localparam int PROD_W       = 2 * CNT_W;
    localparam int DRAIN_CYCLES = 24;
    localparam int PHASE_ITEMS  = 136;

    localparam logic [1:0] GENDER_OTHER    = 2'd2;
    localparam logic [1:0] GENDER_RESERVED = 2'd3;
    localparam logic [1:0] CLASS_MEDIUM    = 2'd1;

    localparam logic [CFG_ADDR_W-1:0] EDGE_REGS [NUM_EDGES] = '{
        REG_EDGE_ONE, REG_EDGE_TWO, REG_EDGE_THREE, REG_EDGE_FOUR, REG_EDGE_FIVE
    };

    typedef struct packed {
        logic              kind;
        logic [1:0]        gender;
        logic [EDGE_W-1:0] height_mm;
        logic [1:0]        label;
    } person_item_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [15:0]           s_tdata = '0;
    logic                  s_tuser = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [7:0]            m_tdata;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [EDGE_W-1:0]     cfg_wdata = '0;

    // Own copy of the block state.
    logic [CNT_W-1:0]  gender_counts [GC_DEPTH];
    logic [CNT_W-1:0]  bin_counts [BC_DEPTH];
    logic [EDGE_W-1:0] bin_edges [NUM_EDGES];

    person_item_t pending_items[$];
    logic [1:0]   awaited_classes[$];
    person_item_t on_bus;
    int           sender_idle_pct = 0;
    int           receiver_stall_pct = 0;
    int           errors = 0;

    count_based_bayes_classifier #(.COUNT_WIDTH(CNT_W)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    initial begin
        #8_000_000;
        $display("count_based_bayes_classifier verification failed");
        $finish;
    end

    // Appends one item to the tail of the pending list.
    function automatic void add_item(input person_item_t it);
        pending_items.insert(pending_items.size(), it);
    endfunction

    function automatic int unsigned height_bin(input logic [EDGE_W-1:0] h);
        for (int b = 0; b < NUM_EDGES; b++) begin
            if (h < bin_edges[b]) return b;
        end
        return NUM_EDGES;
    endfunction

    // Trains the counters or queues the class a query should get.
    function automatic void learn_or_classify(input person_item_t it);
        int unsigned      bin;
        int unsigned      row;
        int unsigned      best;
        logic [PROD_W-1:0] prod;
        logic [PROD_W-1:0] best_prod;
        bin = height_bin(it.height_mm);
        if (it.kind == KIND_TRAIN) begin
            if (it.label != LABEL_UNKNOWN) begin
                if (it.gender == GENDER_MALE || it.gender == GENDER_FEMALE) begin
                    row = it.gender * NUM_CLASSES + it.label;
                    if (gender_counts[row] != '1) gender_counts[row]++;
                end
                if (bin_counts[bin * NUM_CLASSES + it.label] != '1)
                    bin_counts[bin * NUM_CLASSES + it.label]++;
            end
        end else begin
            // Any gender other than male reads the female row.
            row = (it.gender == GENDER_MALE) ? 0 : 1;
            best = 0;
            best_prod = '0;
            for (int c = 0; c < NUM_CLASSES; c++) begin
                prod = PROD_W'(gender_counts[row * NUM_CLASSES + c]) *
                       PROD_W'(bin_counts[bin * NUM_CLASSES + c]);
                if (prod > best_prod) begin
                    best_prod = prod;
                    best = c;
                end
            end
            awaited_classes.insert(awaited_classes.size(), 2'(best));
        end
    endfunction

    function automatic person_item_t make_item(input logic kind, input logic [1:0] gender,
                                               input int h, input logic [1:0] label);
        person_item_t it;
        it.kind = kind;
        it.gender = gender;
        it.height_mm = EDGE_W'(h);
        it.label = label;
        return it;
    endfunction

    // Heights cluster around the edges; labels mostly follow the height.
    function automatic person_item_t random_item(input int classify_pct);
        person_item_t it;
        int unsigned  pick;
        int           h;
        it.kind = ($urandom_range(0, 99) < classify_pct) ? KIND_CLASSIFY : KIND_TRAIN;
        pick = $urandom_range(0, 9);
        it.gender = (pick < 4) ? GENDER_MALE : (pick < 8) ? GENDER_FEMALE :
                    (pick == 8) ? GENDER_OTHER : GENDER_RESERVED;
        if ($urandom_range(0, 3) == 0) begin
            h = $urandom_range(0, 4095);
        end else begin
            h = int'(bin_edges[$urandom_range(0, NUM_EDGES - 1)]) + $urandom_range(0, 200) - 100;
            if (h < 0) h = 0;
            if (h > 4095) h = 4095;
        end
        it.height_mm = EDGE_W'(h);
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
            it.label = 2'(height_bin(it.height_mm) / 2);
        end else if (pick < 88) begin
            it.label = 2'($urandom_range(0, NUM_CLASSES - 1));
        end else begin
            it.label = LABEL_UNKNOWN;
        end
        return it;
    endfunction

    // Stream driver; an item stays on the bus until its transfer completes.
    always @(posedge aclk) begin : drive_items
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) learn_or_classify(on_bus);
            if (!s_tvalid || s_tready) begin
                if (pending_items.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
                    on_bus = pending_items.pop_front();
                    s_tdata <= {on_bus.label, on_bus.height_mm, on_bus.gender};
                    s_tuser <= on_bus.kind;
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin : check_results
        logic [1:0] want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (awaited_classes.size() == 0) begin
                    $error("predicted_class: expected no transfer, got %0d", m_tdata[1:0]);
                    errors++;
                end else begin
                    want = awaited_classes.pop_front();
                    if (m_tdata[1:0] !== want) begin
                        $error("predicted_class: expected %0d, got %0d", want, m_tdata[1:0]);
                        errors++;
                    end
                    if (m_tdata[7:2] !== 6'd0) begin
                        $error("m_tdata padding: expected 0, got %0h", m_tdata[7:2]);
                        errors++;
                    end
                end
            end
            m_tready <= ($urandom_range(0, 99) >= receiver_stall_pct);
        end
    end

    task automatic drain_block();
        while (pending_items.size() != 0 || s_tvalid || awaited_classes.size() != 0)
            @(negedge aclk);
        // Train items give no result, so let the block finish its last one.
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic set_pressure(input int sender_pct, input int receiver_pct);
        @(posedge aclk);
        sender_idle_pct <= sender_pct;
        receiver_stall_pct <= receiver_pct;
    endtask

    task automatic load_bin_edges(input logic [EDGE_W-1:0] vals [NUM_EDGES]);
        for (int i = 0; i < NUM_EDGES; i++) begin
            @(posedge aclk);
            cfg_wr_en <= 1'b1;
            cfg_addr <= EDGE_REGS[i];
            cfg_wdata <= vals[i];
            bin_edges[i] = vals[i];
        end
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic queue_random(input int count, input int classify_pct);
        for (int i = 0; i < count; i++) add_item(random_item(classify_pct));
    endtask

    initial begin
        logic [EDGE_W-1:0] edge_set [NUM_EDGES];
        logic [EDGE_W-1:0] default_edges [NUM_EDGES];
        int                acc;
        default_edges = '{EDGE_ONE_RST, EDGE_TWO_RST, EDGE_THREE_RST, EDGE_FOUR_RST,
                          EDGE_FIVE_RST};
        for (int i = 0; i < GC_DEPTH; i++) gender_counts[i] = '0;
        for (int i = 0; i < BC_DEPTH; i++) bin_counts[i] = '0;
        for (int i = 0; i < NUM_EDGES; i++) bin_edges[i] = default_edges[i];

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: empty tables, exact edges, ignored genders and labels, ties.
        add_item(make_item(KIND_CLASSIFY, GENDER_MALE, 0, CLASS_SHORT));
        add_item(make_item(KIND_TRAIN, GENDER_MALE, 0, CLASS_SHORT));
        add_item(make_item(KIND_TRAIN, GENDER_FEMALE, 1600, CLASS_MEDIUM));
        add_item(make_item(KIND_TRAIN, GENDER_OTHER, 1699, CLASS_TALL));
        add_item(make_item(KIND_TRAIN, GENDER_RESERVED, 4095, CLASS_TALL));
        add_item(make_item(KIND_TRAIN, GENDER_MALE, 2000, LABEL_UNKNOWN));
        add_item(make_item(KIND_TRAIN, GENDER_FEMALE, 1999, CLASS_TALL));
        add_item(make_item(KIND_TRAIN, GENDER_MALE, 1800, CLASS_MEDIUM));
        add_item(make_item(KIND_TRAIN, GENDER_MALE, 1900, CLASS_TALL));
        add_item(make_item(KIND_CLASSIFY, GENDER_MALE, 1999, CLASS_SHORT));
        add_item(make_item(KIND_CLASSIFY, GENDER_FEMALE, 1650, CLASS_SHORT));
        add_item(make_item(KIND_CLASSIFY, GENDER_OTHER, 0, LABEL_UNKNOWN));
        add_item(make_item(KIND_CLASSIFY, GENDER_RESERVED, 4095, CLASS_TALL));
        add_item(make_item(KIND_CLASSIFY, GENDER_MALE, 4095, CLASS_MEDIUM));
        add_item(make_item(KIND_CLASSIFY, GENDER_MALE, 1700, CLASS_SHORT));
        add_item(make_item(KIND_TRAIN, GENDER_MALE, 1599, CLASS_SHORT));
        add_item(make_item(KIND_CLASSIFY, GENDER_MALE, 1599, CLASS_TALL));
        add_item(make_item(KIND_CLASSIFY, GENDER_FEMALE, 2000, CLASS_SHORT));
        drain_block();

        set_pressure(62, 0);
        load_bin_edges(default_edges);
        queue_random(PHASE_ITEMS, 30);
        drain_block();

        set_pressure(0, 62);
        acc = $urandom_range(0, 800);
        for (int i = 0; i < NUM_EDGES; i++) begin
            edge_set[i] = EDGE_W'(acc);
            acc = acc + $urandom_range(0, 800);
            if (acc > 4095) acc = 4095;
        end
        load_bin_edges(edge_set);
        queue_random(PHASE_ITEMS, 30);
        drain_block();

        // All edges at zero put every height in the open bin.
        set_pressure(37, 37);
        edge_set = '{12'd0, 12'd0, 12'd0, 12'd0, 12'd0};
        load_bin_edges(edge_set);
        queue_random(PHASE_ITEMS, 30);
        drain_block();

        set_pressure(0, 0);
        edge_set = '{12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd4095};
        load_bin_edges(edge_set);
        queue_random(PHASE_ITEMS, 30);
        drain_block();

        // Edges out of order: the first edge above the height decides.
        set_pressure(62, 0);
        for (int i = 0; i < NUM_EDGES; i++) edge_set[i] = EDGE_W'($urandom_range(0, 4095));
        load_bin_edges(edge_set);
        queue_random(PHASE_ITEMS, 30);
        drain_block();

        set_pressure(0, 62);
        acc = $urandom_range(0, 4090);
        for (int i = 0; i < NUM_EDGES; i++) edge_set[i] = EDGE_W'(acc + i);
        load_bin_edges(edge_set);
        queue_random(PHASE_ITEMS, 30);
        drain_block();

        set_pressure(37, 37);
        edge_set = '{12'd0, 12'd1, 12'd2047, 12'd4094, 12'd4095};
        load_bin_edges(edge_set);
        queue_random(PHASE_ITEMS, 30);
        drain_block();

        // Push one gender counter and one bin counter well past saturation.
        set_pressure(0, 0);
        load_bin_edges(default_edges);
        for (int i = 0; i < 300; i++) begin
            add_item(make_item(KIND_TRAIN, GENDER_MALE, 1750, CLASS_TALL));
            if (i % 10 == 0)
                add_item(make_item(KIND_CLASSIFY, GENDER_MALE, 1750, CLASS_SHORT));
        end
        queue_random(60, 50);
        drain_block();

        if (errors == 0) begin
            $display("count_based_bayes_classifier verification clean");
        end else begin
            $display("count_based_bayes_classifier verification failed");
        end
        $finish;
    end

endmodule
